/* hdl/isort_pkg.sv */
`default_nettype none

package isort_pkg;

  localparam int DATA_W = 32;
  localparam int DEPTH_DEF = 16;

  typedef logic signed [DATA_W-1:0] isort_data_t;

  typedef struct packed {
    logic        ins;
    logic        drain;
    isort_data_t new_value;
  } isort_ctrl_t;

endpackage

`default_nettype wire

/* hdl/insertion_sorter_core.sv */
// Insertion sorter for sets of signed 32-bit values.
// The input channel (in_valid, in_ready, in_value, in_is_last) takes one value per
// transaction. While a set is being collected, in_ready is high and one value is
// accepted every cycle; each value is inserted into a chain of DEPTH cells that
// keeps the set sorted ascending, with equal values in arrival order.
// The transaction that carries in_is_last is inserted too, and the block then
// emits the set on the output channel (out_valid, out_ready, out_sorted_value,
// out_end_of_set, out_overflowed), smallest first, one result per cycle while
// out_ready is high. The first result is presented in the cycle after the last
// input is accepted. Each accepted value is compared in every cell at once, and
// the chain shifts toward its head by one cell for each result taken.
// in_ready stays low while a set is being emitted and returns high in the cycle
// after the result marked out_end_of_set is taken.
// Values beyond DEPTH in one set are dropped and out_overflowed is high on every
// result of that set. When the receiver stalls, the current result holds and the
// chain does not move. Reset empties the chain and makes the block ready for input.
`default_nettype none

module insertion_sorter_core
  import isort_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [31:0] in_value,
  input  wire logic              in_is_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [31:0]     out_sorted_value,
  output logic                   out_end_of_set,
  output logic                   out_overflowed
);

  localparam logic MODE_FILL  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  logic        mode_r;
  logic        mode_nxt;
  logic        ovf_r;
  logic        ovf_nxt;
  logic        in_acc;
  logic        out_acc;
  logic        full;
  isort_ctrl_t ctrl;

  logic        [DEPTH-1:0] keep;
  logic        [DEPTH-1:0] valid;
  isort_data_t             value [DEPTH];

  assign in_ready = (mode_r == MODE_FILL);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign full     = valid[DEPTH-1];

  assign ctrl.ins       = in_acc && !full;
  assign ctrl.drain     = out_acc;
  assign ctrl.new_value = in_value;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        isort_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .prev_keep  (1'b1),
          .prev_valid (1'b1),
          .prev_value (in_value),
          .next_valid (valid[1]),
          .next_value (value[1]),
          .keep       (keep[0]),
          .valid      (valid[0]),
          .value      (value[0])
        );
      end else if (g == DEPTH - 1) begin : g_tail
        isort_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .prev_keep  (keep[g-1]),
          .prev_valid (valid[g-1]),
          .prev_value (value[g-1]),
          .next_valid (1'b0),
          .next_value ('0),
          .keep       (keep[g]),
          .valid      (valid[g]),
          .value      (value[g])
        );
      end else begin : g_mid
        isort_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .prev_keep  (keep[g-1]),
          .prev_valid (valid[g-1]),
          .prev_value (value[g-1]),
          .next_valid (valid[g+1]),
          .next_value (value[g+1]),
          .keep       (keep[g]),
          .valid      (valid[g]),
          .value      (value[g])
        );
      end
    end
  endgenerate

  assign out_valid        = (mode_r == MODE_DRAIN) && valid[0];
  assign out_sorted_value = value[0];
  assign out_end_of_set   = !valid[1];
  assign out_overflowed   = ovf_r;

  always_comb begin
    mode_nxt = mode_r;
    ovf_nxt  = ovf_r;
    unique case (mode_r)
      MODE_FILL: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            mode_nxt = MODE_DRAIN;
          end
        end
      end
      MODE_DRAIN: begin
        if (out_acc && out_end_of_set) begin
          mode_nxt = MODE_FILL;
          ovf_nxt  = 1'b0;
        end
      end
      default: begin
        mode_nxt = MODE_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FILL;
      ovf_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DRAIN) |-> valid[0])
    else $error("Drain mode entered with an empty chain.");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid >> 1) & ~valid) == '0)
    else $error("Cell valid bits are not a contiguous prefix.");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_is_last) |=> (out_valid && !in_ready))
    else $error("Last transaction did not start output.");

  a_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_end_of_set) |=> (in_ready && !valid[0] && !out_overflowed))
    else $error("Chain not empty after the final result.");

  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> out_overflowed)
    else $error("Dropped value did not raise the overflow flag.");

endmodule

`default_nettype wire

/* hdl/isort_cell.sv */
`default_nettype none

module isort_cell
  import isort_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire isort_ctrl_t ctrl,
  input  wire logic        prev_keep,
  input  wire logic        prev_valid,
  input  wire isort_data_t prev_value,
  input  wire logic        next_valid,
  input  wire isort_data_t next_value,
  output logic             keep,
  output logic             valid,
  output isort_data_t      value
);

  logic        valid_r;
  logic        valid_nxt;
  isort_data_t value_r;
  isort_data_t value_nxt;

  assign keep  = valid_r && !(value_r > ctrl.new_value);
  assign valid = valid_r;
  assign value = value_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.drain) begin
      valid_nxt = next_valid;
      value_nxt = next_value;
    end else if (ctrl.ins && !keep) begin
      valid_nxt = valid_r | prev_valid;
      value_nxt = prev_keep ? ctrl.new_value : prev_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench;
  import isort_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS_PER_PHASE = 95;
  localparam isort_data_t MIN_VALUE = 32'sh8000_0000;
  localparam isort_data_t MAX_VALUE = 32'sh7fff_ffff;

  typedef enum int {
    VALUES_FULL,
    VALUES_NARROW,
    VALUES_EDGES
  } value_style_t;

  typedef struct {
    isort_data_t value;
    logic        end_of_set;
    logic        overflowed;
  } sorted_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  isort_data_t in_value;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  isort_data_t out_sorted_value;
  logic        out_end_of_set;
  logic        out_overflowed;

  isort_data_t    model_store [DEPTH_DEF];
  int             model_fill;
  bit             model_overflow;
  sorted_result_t pending_sorted [$];

  int fail_count;
  int values_accepted;
  int sets_sorted;
  int overflow_sets;
  int results_checked;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;

  insertion_sorter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_end_of_set   (out_end_of_set),
    .out_overflowed   (out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void insert_and_sort(isort_data_t v, logic last);
    int pos;
    sorted_result_t r;
    if (model_fill >= DEPTH_DEF) begin
      model_overflow = 1'b1;
    end else begin
      pos = model_fill;
      while (pos > 0 && model_store[pos-1] > v) begin
        model_store[pos] = model_store[pos-1];
        pos--;
      end
      model_store[pos] = v;
      model_fill++;
    end
    if (last) begin
      for (int k = 0; k < model_fill; k++) begin
        r.value = model_store[k];
        r.end_of_set = (k + 1 == model_fill);
        r.overflowed = model_overflow;
        pending_sorted.push_back(r);
      end
      sets_sorted++;
      if (model_overflow) begin
        overflow_sets++;
      end
      model_fill = 0;
      model_overflow = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      values_accepted++;
      insert_and_sort(in_value, in_is_last);
    end
  end

  always @(posedge clk) begin : check_results
    sorted_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result value=%0d end_of_set=%b overflowed=%b",
                 $time, out_sorted_value, out_end_of_set, out_overflowed);
        fail_count++;
      end else begin
        want = pending_sorted.pop_front();
        results_checked++;
        if (out_sorted_value !== want.value) begin
          $display("%0t: sorted_value expected %0d actual %0d",
                   $time, want.value, out_sorted_value);
          fail_count++;
        end
        if (out_end_of_set !== want.end_of_set) begin
          $display("%0t: end_of_set expected %b actual %b",
                   $time, want.end_of_set, out_end_of_set);
          fail_count++;
        end
        if (out_overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %b actual %b",
                   $time, want.overflowed, out_overflowed);
          fail_count++;
        end
      end
    end
  end

  // The receiver normally stalls at random; on request it holds off for a
  // long stretch so that the chain fills up and the input side backs up.
  initial begin : receiver
    int held;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(posedge clk);
        end
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_value(isort_data_t v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic isort_data_t pick_value(value_style_t style);
    isort_data_t edges [7];
    edges = '{MIN_VALUE, MIN_VALUE + 1, -1, 0, 1, MAX_VALUE - 1, MAX_VALUE};
    case (style)
      VALUES_FULL: begin
        return isort_data_t'($urandom);
      end
      VALUES_NARROW: begin
        return isort_data_t'(int'($urandom_range(16)) - 8);
      end
      default: begin
        return edges[$urandom_range(6)];
      end
    endcase
  endfunction

  task automatic send_set(int size, value_style_t style);
    for (int i = 0; i < size; i++) begin
      send_value(pick_value(style), i == size - 1);
    end
  endtask

  task automatic test_extremes();
    send_value(MAX_VALUE, 1'b0);
    send_value(0, 1'b0);
    send_value(MIN_VALUE, 1'b0);
    send_value(-1, 1'b0);
    send_value(1, 1'b0);
    send_value(MIN_VALUE, 1'b1);
  endtask

  task automatic test_single_value_set();
    send_value(-32'sd5, 1'b1);
  endtask

  // Seventeen values in descending order: the chain shifts on every insert,
  // and the final one, which carries the last mark, is dropped.
  task automatic test_overflow();
    for (int i = 16; i >= 0; i--) begin
      send_value(isort_data_t'(i * 3 - 20), i == 0);
    end
  endtask

  task automatic test_random_traffic(int sender_pct, int receiver_pct);
    int target;
    int size;
    int roll;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    target = values_accepted + RANDOM_ITEMS_PER_PHASE;
    while (values_accepted < target) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        size = DEPTH_DEF + 1 + $urandom_range(5);
      end else if (roll < 30) begin
        size = DEPTH_DEF;
      end else if (roll < 45) begin
        size = 1 + $urandom_range(2);
      end else begin
        size = 1 + $urandom_range(DEPTH_DEF - 1);
      end
      send_set(size, value_style_t'($urandom_range(2)));
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    for (int s = 0; s < 3; s++) begin
      send_set(10, VALUES_FULL);
    end
  endtask

  initial begin
    fail_count = 0;
    values_accepted = 0;
    sets_sorted = 0;
    overflow_sets = 0;
    results_checked = 0;
    model_fill = 0;
    model_overflow = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    in_is_last <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_single_value_set();
    test_overflow();
    test_random_traffic(22, 83);
    test_random_traffic(83, 22);
    test_random_traffic(0, 0);
    test_backpressure();

    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sorted %0d sets from %0d values, %0d of them overflowed.",
             sets_sorted, values_accepted, overflow_sets);
    $display("Checked %0d results under random stalls on both sides and a long hold-off.",
             results_checked);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results still outstanding.", pending_sorted.size());
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
